FILE: design/trb_pkg.sv
// Shared types and constants for the timestamp reorder buffer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package trb_pkg;

	localparam int CNT_W  = 12;
	localparam int RATE_W = 16;
	localparam int REC_W  = 16;
	localparam int TIME_W = 32;
	localparam int CH_W   = 4;
	localparam int DEP_W  = 7;

	typedef logic [2:0] kind_t;

	localparam kind_t K_REL = 3'd0;
	localparam kind_t K_FRC = 3'd1;
	localparam kind_t K_FST = 3'd2;
	localparam kind_t K_HLD = 3'd3;
	localparam kind_t K_DUP = 3'd4;
	localparam kind_t K_LAT = 3'd5;
	localparam kind_t K_IGN = 3'd6;

	typedef struct packed {
		logic [REC_W-1:0]  rec;
		logic [TIME_W-1:0] en;
		logic [TIME_W-1:0] st;
	} slot_t;

	typedef struct packed {
		logic  latch;
		logic  start_ch;
		logic  pend_inp;
		kind_t pend_kind;
		logic  rd_head;
		logic  pop;
		logic  cur_init;
		logic  rd_cur;
		logic  shift;
		logic  put_new;
		logic  load_out;
		logic  out_last;
	} trb_cmd_t;

	typedef struct packed {
		logic ignored;
		logic div_busy;
		logic e_zero;
		logic dup;
		logic late;
		logic full;
		logic cur_zero;
		logic rd_gt;
		logic rel_ok;
		logic fill_one;
		logic held;
		logic pend_v;
		logic out_free;
	} trb_sts_t;

endpackage
`default_nettype wire

FILE: design/trb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module trb_ram #(
	parameter int W = 80,
	parameter int D = 512
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// write and registered read; read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: design/trb_ctrl.sv
// Controller state machine of the timestamp reorder buffer.
// Depends on trb_pkg; drives the datapath through trb_cmd_t, reads trb_sts_t.
`timescale 1ns / 1ps
`default_nettype none
module trb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire trb_pkg::trb_sts_t  sts,
	output trb_pkg::trb_cmd_t       cmd
);
	import trb_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_EN   = 4'd3;
	localparam logic [3:0] S_CLS  = 4'd4;
	localparam logic [3:0] S_FRD  = 4'd5;
	localparam logic [3:0] S_FWT  = 4'd6;
	localparam logic [3:0] S_CUR  = 4'd7;
	localparam logic [3:0] S_INS  = 4'd8;
	localparam logic [3:0] S_IWT  = 4'd9;
	localparam logic [3:0] S_RRD  = 4'd10;
	localparam logic [3:0] S_RWT  = 4'd11;
	localparam logic [3:0] S_END  = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	logic [3:0] state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.ignored) begin
					cmd.pend_inp  = 1'b1;
					cmd.pend_kind = K_IGN;
					state_d       = S_FIN;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_EN;
				end
			end
			S_EN: state_d = S_CLS;
			S_CLS: begin
				if (sts.e_zero) begin
					cmd.start_ch  = 1'b1;
					cmd.pend_inp  = 1'b1;
					cmd.pend_kind = K_FST;
					state_d       = S_FIN;
				end else if (sts.dup) begin
					cmd.pend_inp  = 1'b1;
					cmd.pend_kind = K_DUP;
					state_d       = S_FIN;
				end else if (sts.late) begin
					cmd.pend_inp  = 1'b1;
					cmd.pend_kind = K_LAT;
					state_d       = S_FIN;
				end else if (sts.full) begin
					state_d = S_FRD;
				end else begin
					state_d = S_CUR;
				end
			end
			S_FRD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_FWT;
			end
			S_FWT: begin
				cmd.pop       = 1'b1;
				cmd.pend_kind = K_FRC;
				state_d       = S_CUR;
			end
			S_CUR: begin
				cmd.cur_init = 1'b1;
				state_d      = S_INS;
			end
			S_INS: begin
				if (sts.cur_zero) begin
					cmd.put_new = 1'b1;
					state_d     = S_RRD;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_IWT;
				end
			end
			S_IWT: begin
				if (sts.rd_gt) begin
					cmd.shift = 1'b1;
					state_d   = S_INS;
				end else begin
					cmd.put_new = 1'b1;
					state_d     = S_RRD;
				end
			end
			S_RRD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_RWT;
			end
			S_RWT: begin
				if (!sts.rel_ok) begin
					state_d = S_END;
				end else if (!sts.pend_v || sts.out_free) begin
					cmd.load_out  = sts.pend_v;
					cmd.pop       = 1'b1;
					cmd.pend_kind = K_REL;
					state_d       = sts.fill_one ? S_END : S_RRD;
				end
			end
			S_END: begin
				if (!sts.held) begin
					state_d = S_FIN;
				end else if (!sts.pend_v || sts.out_free) begin
					cmd.load_out  = sts.pend_v;
					cmd.pend_inp  = 1'b1;
					cmd.pend_kind = K_HLD;
					state_d       = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

FILE: design/trb_dp.sv
// Datapath of the timestamp reorder buffer: input latch, divider, channel state,
// slot memory walk, pending result and output register. Depends on trb_pkg, trb_ram.
`timescale 1ns / 1ps
`default_nettype none
module trb_dp #(
	parameter int CHANNELS = 16,
	parameter int DEPTH    = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [79:0]       s_tdata,
	input  wire logic              cfg_valid,
	input  wire logic [5:0]        cfg_data,
	input  wire trb_pkg::trb_cmd_t cmd,
	output trb_pkg::trb_sts_t      sts,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [87:0]            m_tdata,
	output logic                   m_tlast
);
	import trb_pkg::*;

	localparam int NCH = (CHANNELS < 16) ? CHANNELS : 16;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int FW  = $clog2(DEPTH + 1);
	localparam int IW  = $clog2(DEPTH);
	localparam int ND  = NCH * DEPTH;
	localparam int AW  = $clog2(ND);

	// map a slot offset from the channel head to a physical slot
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
	                                          input logic [FW-1:0] off);
		logic [FW:0] p;
		p = (FW+1)'(head) + (FW+1)'(off);
		if (p >= (FW+1)'(DEPTH)) begin
			p = p - (FW+1)'(DEPTH);
		end
		return IW'(p);
	endfunction

	logic [CH_W-1:0]   ch_q;
	logic              ch_ok_q;
	logic [REC_W-1:0]  rec_q;
	logic [TIME_W-1:0] st_q, en_q;
	logic [RATE_W-1:0] rate_q, rem_q;
	logic [CNT_W-1:0]  num_q;
	logic [3:0]        dcnt_q;
	logic [DEP_W-1:0]  dep_q, lim;
	logic [TIME_W-1:0] nexp_q [NCH];
	logic [FW-1:0]     fill_q [NCH];
	logic [IW-1:0]     head_q [NCH];
	logic [CW-1:0]     chi;
	logic [TIME_W-1:0] e;
	logic [FW-1:0]     fill_c, cur_q, npos_q, rd_off;
	logic [IW-1:0]     head_c;
	logic              held_q;
	logic [RATE_W:0]   trial;
	logic              qbit;
	slot_t             rd_s, wr_s;
	logic [AW-1:0]     raddr, waddr;
	logic              pv_q;
	slot_t             p_q;
	kind_t             pk_q;
	logic              ov_q, ol_q;
	slot_t             o_q;
	kind_t             ok_q;
	logic [CH_W-1:0]   och_q;

	assign chi    = ch_ok_q ? CW'(ch_q) : '0;
	assign e      = nexp_q[chi];
	assign fill_c = fill_q[chi];
	assign head_c = head_q[chi];
	assign lim    = (dep_q < DEP_W'(2)) ? DEP_W'(2) :
	                (dep_q > DEP_W'(DEPTH)) ? DEP_W'(DEPTH) : dep_q;

	// status towards the controller
	assign sts.ignored  = !ch_ok_q || (rate_q == '0);
	assign sts.div_busy = (dcnt_q != '0);
	assign sts.e_zero   = (e == '0);
	assign sts.dup      = (st_q <= e) && (en_q == e);
	assign sts.late     = (st_q < e);
	assign sts.full     = (8'(fill_c) + 8'd1) >= 8'(lim);
	assign sts.cur_zero = (cur_q == '0);
	assign sts.rd_gt    = (rd_s.st > st_q);
	assign sts.rel_ok   = (rd_s.st <= e);
	assign sts.fill_one = (fill_c == FW'(1));
	assign sts.held     = held_q;
	assign sts.pend_v   = pv_q;
	assign sts.out_free = !ov_q || m_tready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_q <= DEP_W'(DEPTH);
		end else if (cfg_valid) begin
			dep_q <= {1'b0, cfg_data};
		end
	end

	// latch input and run restoring division, one quotient bit a cycle
	assign trial = {rem_q, num_q[CNT_W-1]};
	assign qbit  = (trial >= {1'b0, rate_q});

	always_ff @(posedge clk) begin
		en_q <= st_q + TIME_W'(num_q);
		if (cmd.latch) begin
			ch_q    <= s_tdata[3:0];
			rec_q   <= s_tdata[19:4];
			st_q    <= s_tdata[51:20];
			num_q   <= s_tdata[63:52];
			rate_q  <= s_tdata[79:64];
			ch_ok_q <= (32'(s_tdata[3:0]) < CHANNELS);
			rem_q   <= '0;
		end else if (dcnt_q != '0) begin
			rem_q <= qbit ? RATE_W'(trial - {1'b0, rate_q}) : RATE_W'(trial);
			num_q <= {num_q[CNT_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.latch) begin
			dcnt_q <= 4'(CNT_W);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 4'd1;
		end
	end

	// per-channel expected start, fill and head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				nexp_q[i] <= '0;
				fill_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else begin
			if (cmd.start_ch) begin
				fill_q[chi] <= '0;
				nexp_q[chi] <= en_q;
			end else if (cmd.pop) begin
				fill_q[chi] <= fill_c - FW'(1);
				nexp_q[chi] <= rd_s.en;
				head_q[chi] <= slot_of(head_c, FW'(1));
			end else if (cmd.put_new) begin
				fill_q[chi] <= fill_c + FW'(1);
			end
		end
	end

	// insertion cursor and tracking of the new block's place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			cur_q  <= '0;
			npos_q <= '0;
		end else begin
			if (cmd.cur_init) begin
				cur_q <= fill_c;
			end else if (cmd.shift) begin
				cur_q <= cur_q - FW'(1);
			end
			if (cmd.latch) begin
				held_q <= 1'b0;
			end else if (cmd.put_new) begin
				held_q <= 1'b1;
				npos_q <= cur_q;
			end else if (cmd.pop && cmd.pend_kind == K_REL && held_q) begin
				if (npos_q == '0) begin
					held_q <= 1'b0;
				end else begin
					npos_q <= npos_q - FW'(1);
				end
			end
		end
	end

	// slot memory
	assign rd_off = cmd.rd_cur ? cur_q - FW'(1) : '0;
	assign raddr  = AW'(chi * DEPTH) + AW'(slot_of(head_c, rd_off));
	assign waddr  = AW'(chi * DEPTH) + AW'(slot_of(head_c, cur_q));
	assign wr_s   = cmd.shift ? rd_s : slot_t'{rec: rec_q, en: en_q, st: st_q};

	trb_ram #(.W($bits(slot_t)), .D(ND)) u_ram (
		.clk   (clk),
		.we    (cmd.shift || cmd.put_new),
		.waddr (waddr),
		.wdata (wr_s),
		.re    (cmd.rd_head || cmd.rd_cur),
		.raddr (raddr),
		.rdata (rd_s)
	);

	// pending result, held back until it is known whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (cmd.pend_inp || cmd.pop) begin
			pv_q <= 1'b1;
		end else if (cmd.load_out) begin
			pv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_inp) begin
			pk_q     <= cmd.pend_kind;
			p_q.rec  <= rec_q;
			p_q.st   <= st_q;
			p_q.en   <= (cmd.pend_kind == K_IGN) ? '0 : en_q;
		end else if (cmd.pop) begin
			pk_q <= cmd.pend_kind;
			p_q  <= rd_s;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_out) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_q   <= p_q;
			ok_q  <= pk_q;
			ol_q  <= cmd.out_last;
			och_q <= ch_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tlast  = ol_q;
	assign m_tdata  = {1'b0, ok_q, o_q.en, o_q.st, o_q.rec, och_q};

	// a result is moved out only when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!ov_q || m_tready))
		else $error("output register overwritten");

	// no pop from an empty channel
	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (fill_c != '0))
		else $error("pop from empty channel");

	// an insert never overflows the physical slots of a channel
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_new |-> ((8'(fill_c) + 8'd1) < 8'(DEPTH)))
		else $error("insert beyond channel slots");

	// a shift always has a slot below the cursor
	a_shift_cur: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (cur_q != '0))
		else $error("shift at cursor zero");
endmodule
`default_nettype wire

FILE: design/timestamp_reorder_buffer.sv
// Top level of the timestamp reorder buffer: controller plus datapath.
// Depends on trb_pkg, trb_ctrl, trb_dp (which holds trb_ram).
//
// channel | direction | handshake          | content
// s_      | in        | s_tvalid/s_tready  | one timestamped block
// m_      | out       | m_tvalid/m_tready  | one result, m_tlast on the final one
// cfg_    | in        | cfg_valid/cfg_ready| depth_in_use
//
// One block at a time. The time an item takes grows with each slot shifted during the
// sorted insert and each block released; the divider and the slot walk set it.
// The output register lets the next block be accepted while the last result waits.
// Reset clears channel state at once; slot memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_reorder_buffer #(
	parameter int CHANNELS = 16,
	parameter int DEPTH    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// channel[3:0], record_id[19:4], start_time[51:20], sample_count[63:52],
	// rate[79:64]
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_channel[3:0], out_record[19:4], out_start[51:20], out_end[83:52],
	// kind[86:84], zero[87]
	output logic [87:0]      m_tdata,
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data
);
	import trb_pkg::*;

	trb_cmd_t cmd;
	trb_sts_t sts;

	assign cfg_ready = 1'b1;

	trb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trb_dp #(.CHANNELS(CHANNELS), .DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);
endmodule
`default_nettype wire

FILE: sim/timestamp_reorder_buffer_tb.sv
// Self-checking testbench for timestamp_reorder_buffer: drives timestamped blocks,
// predicts release order per channel and checks every result transfer.
// Depends on trb_pkg and the timestamp_reorder_buffer RTL.
`timescale 1ns / 1ps

module timestamp_reorder_buffer_tb;
	import trb_pkg::*;

	localparam int NCH = 16;
	localparam int NDEP = 32;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] en;
		logic [31:0] st;
		logic [15:0] rec;
		logic [3:0]  ch;
		logic        last;
	} result_t;

	// Scoreboard: tracks per-channel buffer state and pending results
	class reorder_scoreboard;
		logic [31:0] next_exp [NCH];
		int          fill [NCH];
		logic [31:0] h_st [NCH][NDEP];
		logic [31:0] h_en [NCH][NDEP];
		logic [15:0] h_rec [NCH][NDEP];
		logic [5:0]  depth_reg;
		result_t     pending[$];
		int          errors;

		function void reset_state();
			for (int c = 0; c < NCH; c++) begin
				next_exp[c] = 0;
				fill[c] = 0;
			end
			depth_reg = NDEP;
			pending.delete();
			errors = 0;
		endfunction

		function void push(logic [3:0] c, logic [15:0] r, logic [31:0] s, logic [31:0] e,
				kind_t k);
			result_t x;
			x.ch = c; x.rec = r; x.st = s; x.en = e; x.kind = k; x.last = 1'b0;
			pending.push_back(x);
		endfunction

		function void take_front(int c, output logic [31:0] s, output logic [31:0] e,
				output logic [15:0] r);
			s = h_st[c][0]; e = h_en[c][0]; r = h_rec[c][0];
			for (int i = 0; i + 1 < fill[c]; i++) begin
				h_st[c][i] = h_st[c][i+1];
				h_en[c][i] = h_en[c][i+1];
				h_rec[c][i] = h_rec[c][i+1];
			end
			fill[c]--;
		endfunction

		// Note an accepted block and queue its expected results
		function void note_block(logic [79:0] d);
			logic [3:0]  c;
			logic [15:0] r, rr;
			logic [31:0] s, e, ex, rs, re;
			logic [11:0] cnt;
			logic [15:0] rate;
			int          lim, pos, newpos;
			bit          held;
			c = d[3:0]; r = d[19:4]; s = d[51:20]; cnt = d[63:52]; rate = d[79:64];
			if (rate == 0) begin
				push(c, r, s, 0, K_IGN);
			end else begin
				e = s + 32'(cnt / rate);
				ex = next_exp[c];
				if (ex == 0) begin
					fill[c] = 0;
					next_exp[c] = e;
					push(c, r, s, e, K_FST);
				end else if (s <= ex && e == ex) begin
					push(c, r, s, e, K_DUP);
				end else if (s < ex) begin
					push(c, r, s, e, K_LAT);
				end else begin
					lim = depth_reg;
					if (lim < 2) lim = 2;
					if (lim > NDEP) lim = NDEP;
					if (fill[c] > 0 && fill[c] + 1 >= lim) begin
						take_front(c, rs, re, rr);
						next_exp[c] = re;
						push(c, rr, rs, re, K_FRC);
					end
					pos = fill[c];
					while (pos > 0 && h_st[c][pos-1] > s) begin
						h_st[c][pos] = h_st[c][pos-1];
						h_en[c][pos] = h_en[c][pos-1];
						h_rec[c][pos] = h_rec[c][pos-1];
						pos--;
					end
					h_st[c][pos] = s; h_en[c][pos] = e; h_rec[c][pos] = r;
					fill[c]++;
					newpos = pos;
					held = 1;
					while (fill[c] > 0 && h_st[c][0] <= next_exp[c]) begin
						take_front(c, rs, re, rr);
						next_exp[c] = re;
						push(c, rr, rs, re, K_REL);
						if (held) begin
							if (newpos == 0) held = 0;
							else newpos--;
						end
					end
					if (held) push(c, r, s, e, K_HLD);
				end
			end
			pending[pending.size()-1].last = 1'b1;
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(logic [87:0] d, logic l);
			result_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result tdata=%h last=%b", $time, d, l);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (d[3:0] !== x.ch || d[19:4] !== x.rec || d[51:20] !== x.st
					|| d[83:52] !== x.en || d[86:84] !== x.kind || d[87] !== 1'b0
					|| l !== x.last) begin
				$display("%0t: mismatch expected ch=%0d rec=%h st=%h en=%h kind=%0d last=%b",
					$time, x.ch, x.rec, x.st, x.en, x.kind, x.last);
				$display("%0t:          actual   ch=%0d rec=%h st=%h en=%h kind=%0d last=%b",
					$time, d[3:0], d[19:4], d[51:20], d[83:52], d[86:84], l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	reorder_scoreboard sb;
	logic [31:0] chan_time [NCH];
	int          cycles;
	bit          stall_mode;

	timestamp_reorder_buffer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check results and bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
		if (cycles > 2000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver stall pattern: alternate free-running stretches with random stalls
	always @(negedge clk) begin
		if (($urandom & 63) == 0) stall_mode <= ~stall_mode;
		if (stall_mode) m_tready <= ($urandom_range(0, 3) != 0);
		else m_tready <= 1'b1;
	end

	task automatic send_block(logic [3:0] c, logic [15:0] r, logic [31:0] s,
			logic [11:0] cnt, logic [15:0] rate);
		s_tdata <= {rate, cnt, s, r, c};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_block({rate, cnt, s, r, c});
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_depth(logic [5:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.depth_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random block on a channel: mostly in order or small gaps, some duplicates/late
	task automatic random_block(int c);
		logic [31:0] s;
		logic [11:0] cnt;
		logic [15:0] rate;
		int          sel;
		rate = ($urandom_range(0, 40) == 0) ? 16'd0 :
			($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 1000)));
		cnt = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) :
			12'($urandom_range(0, 2048));
		sel = $urandom_range(0, 9);
		if (sel < 5) s = chan_time[c] + $urandom_range(0, 2);
		else if (sel < 8) s = chan_time[c] + $urandom_range(0, 12);
		else if (sel < 9) s = chan_time[c] - $urandom_range(0, 5);
		else s = $urandom;
		if (sb.next_exp[c] == 0 && $urandom_range(0, 1)) s = chan_time[c];
		send_block(4'(c), 16'($urandom), s, cnt, rate);
		if (rate != 0) chan_time[c] = s + 32'(cnt / rate);
	endtask

	initial begin
		int burst;
		sb = new();
		sb.reset_state();
		cycles = 0;
		stall_mode = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: ignore, first passthrough, gap hold, release, duplicate, late
		send_block(4'd0, 16'h0000, 32'd0, 12'd0, 16'd0);
		send_block(4'd15, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 16'd0);
		send_block(4'd1, 16'h0001, 32'd100, 12'd2048, 16'd1000);
		send_block(4'd1, 16'h0002, 32'd110, 12'd10, 16'd1);
		send_block(4'd1, 16'h0003, 32'd105, 12'd5, 16'd1);
		send_block(4'd1, 16'h0004, 32'd102, 12'd3, 16'd1);
		send_block(4'd1, 16'h0005, 32'd102, 12'd3, 16'd1);
		send_block(4'd1, 16'h0006, 32'd101, 12'd0, 16'hFFFF);
		send_block(4'd1, 16'h0007, 32'd120, 12'd1, 16'd1);
		send_block(4'd1, 16'h0008, 32'd120, 12'd1, 16'd1);
		send_block(4'd2, 16'h0009, 32'd0, 12'd0, 16'd5);
		send_block(4'd2, 16'h000A, 32'hFFFF_FFFF, 12'd2048, 16'd1);
		send_block(4'd2, 16'h000B, 32'hFFFF_FFFF, 12'hFFF, 16'd1);
		drain();

		// Small depth forces releases; also cover out-of-range settings
		write_depth(6'd0);
		send_block(4'd3, 16'h0010, 32'd500, 12'd1, 16'd1);
		send_block(4'd3, 16'h0011, 32'd510, 12'd1, 16'd1);
		send_block(4'd3, 16'h0012, 32'd520, 12'd1, 16'd1);
		send_block(4'd3, 16'h0013, 32'd530, 12'd1, 16'd1);
		drain();
		write_depth(6'd63);
		for (int i = 0; i < 8; i++) send_block(4'd4, 16'(i), 32'd900 - 32'(i), 12'd1, 16'd1);
		drain();

		for (int c = 0; c < NCH; c++) chan_time[c] = $urandom_range(1, 1000000);

		// Random phases across several depth settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_depth(6'd2);
				1: write_depth(6'd32);
				2: write_depth(6'($urandom_range(3, 12)));
				3: write_depth(6'd1);
				4: write_depth(6'($urandom));
				default: write_depth(6'd5);
			endcase
			for (int i = 0; i < 70; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++) begin
					random_block($urandom_range(0, 3) == 0 ?
						$urandom_range(0, NCH - 1) : $urandom_range(0, 3));
					i++;
				end
				if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 150));
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/trb_pkg.sv
design/trb_ram.sv
design/trb_ctrl.sv
design/trb_dp.sv
design/timestamp_reorder_buffer.sv
sim/timestamp_reorder_buffer_tb.sv
